[src/ttrr_pkg.sv]
// Shared types and constants for the round-robin task table scheduler.
// No dependencies.
package ttrr_pkg;
    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int USED_W     = $clog2(TASK_SLOTS + 1);

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_CREATE   = 3'd1,
        MODE_RUN      = 3'd2,
        MODE_EXIT     = 3'd3,
        MODE_READY    = 3'd4,
        MODE_SLEEP    = 3'd5,
        MODE_WAKE     = 3'd6,
        MODE_SELECT   = 3'd7
    } t_mode;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_EXITED  = 2'd3;

    localparam logic [1:0] RS_OK      = 2'd0;
    localparam logic [1:0] RS_REFUSED = 2'd1;
    localparam logic [1:0] RS_NOTASK  = 2'd2;
    localparam logic [1:0] RS_NONE    = 2'd3;

    localparam logic [1:0] KIND_KERNEL = 2'd0;
    localparam logic [1:0] KIND_USER   = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] parent;
        logic [1:0]  status;
        logic        user;
        logic        service;
        logic        launchable;
        logic [63:0] deadline;
        logic [31:0] window;
    } t_slot;
endpackage

[src/ttrr_slot_ram.sv]
// Task slot storage: one synchronous memory of slot records.
// Depends on ttrr_pkg.
module ttrr_slot_ram
    import ttrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  t_slot             i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_slot             o_rdata
);
    t_slot r_mem [TASK_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/task_table_round_robin_scheduler_core.sv]
// Round-robin task table scheduler top level.
// Create, ready, sleep and wake sweep the table once, the other requests twice, and busy stays
// high while a request is in progress.
// Throughput: one request at a time, set by the single read and write port of the slot RAM.
// Reset (synchronous, active low) clears counters and control; slot RAM needs no clearing.
// The result strobe lasts one cycle, in the first cycle with busy low; the receiver cannot stall.
module task_table_round_robin_scheduler_core
    import ttrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_task_id,
    input  logic [31:0] i_parent_id,
    input  logic [1:0]  i_task_kind,
    input  logic        i_service_flag,
    input  logic        i_launchable,
    input  logic [63:0] i_wake_deadline,
    input  logic [31:0] i_window_id,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_id,
    output logic [63:0] o_tick_count,
    output logic [63:0] o_busy_ticks,
    output logic [63:0] o_idle_ticks
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MID, S_APPLY, S_DONE} t_state;

    t_state            r_state;
    t_mode             r_mode;
    logic [31:0]       r_tid, r_pid, r_win;
    logic [1:0]        r_kind;
    logic              r_svc, r_launch;
    logic [63:0]       r_dl;
    logic              r_pass;
    logic [USED_W-1:0] r_cnt;
    logic              r_rvalid;
    logic [SLOT_W-1:0] r_raddr_q;
    logic [USED_W-1:0] r_used;
    logic [31:0]       r_next_id, r_cur_id;
    logic [63:0]       r_tick, r_busy, r_idle;
    logic              r_f_hit, r_c_hit, r_x_hit, r_sel_hit, r_hit_any;
    logic [SLOT_W-1:0] r_f_idx, r_c_idx, r_x_idx;
    t_slot             r_f_slot, r_c_slot;
    logic [31:0]       r_sel_id;
    logic [1:0]        r_res_status;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    t_slot             ram_wdata, rd;

    ttrr_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    // pass 0: scan lookups; pass 1: per-slot rewrite, or select sweep
    logic [USED_W-1:0] sweep_idx;
    logic [USED_W-1:0] sel_base;
    logic [USED_W:0]   sel_sum;
    always_comb begin
        sel_base = r_c_hit ? USED_W'(r_c_idx) : '0;
        sel_sum  = {1'b0, sel_base} + {1'b0, r_cnt} + 1'b1;
        if (sel_sum >= {1'b0, r_used}) sel_sum = sel_sum - {1'b0, r_used};
        if (sel_sum >= {1'b0, r_used}) sel_sum = sel_sum - {1'b0, r_used};
        sweep_idx = (r_mode == MODE_SELECT && r_pass) ? sel_sum[USED_W-1:0] : r_cnt;
        ram_raddr = sweep_idx[SLOT_W-1:0];
    end

    logic scan_issue;
    assign scan_issue = (r_state == S_SCAN || r_state == S_MID) && (r_cnt < r_used);

    // writeback in pass 1 for per-slot modes
    t_slot wb;
    logic  wb_en;
    logic  eligible;
    always_comb begin
        wb = rd;
        wb_en = 1'b0;
        eligible = rd.user && rd.status == ST_READY && rd.launchable;
        unique case (r_mode)
            MODE_TICK: begin
                if (rd.status == ST_BLOCKED && rd.deadline != '0 && rd.deadline <= r_tick) begin
                    wb.status = ST_READY; wb.deadline = '0; wb.window = '0; wb_en = 1'b1;
                end
            end
            MODE_RUN: begin
                if (rd.id == r_tid) begin
                    wb.status = ST_RUNNING; wb_en = 1'b1;
                end else if (rd.status == ST_RUNNING) begin
                    wb.status = ST_READY; wb_en = 1'b1;
                end
            end
            MODE_EXIT: begin
                if (rd.parent == r_tid) begin
                    wb.parent = '0; wb_en = 1'b1;
                end
                if (r_f_hit && r_raddr_q == r_f_idx) begin
                    wb.status = ST_EXITED; wb_en = 1'b1;
                end
            end
            default: ;
        endcase
    end

    logic per_slot_mode;
    assign per_slot_mode = r_mode == MODE_TICK || r_mode == MODE_RUN || r_mode == MODE_EXIT;

    // single-slot update for create / ready / sleep / wake
    t_slot             ap;
    logic              ap_en;
    logic [SLOT_W-1:0] ap_idx;
    logic [1:0]        ap_status;
    logic [31:0]       ap_rid;
    logic              ap_new;
    always_comb begin
        ap = r_f_slot;
        ap_en = 1'b0;
        ap_idx = r_f_idx;
        ap_status = RS_OK;
        ap_rid = '0;
        ap_new = 1'b0;
        unique case (r_mode)
            MODE_CREATE: begin
                ap = '0;
                if (r_kind == KIND_IDLE) begin
                    ap.status = ST_RUNNING;
                end else begin
                    ap.id = r_next_id;
                    ap.status = ST_READY;
                    if (r_kind == KIND_USER) begin
                        ap.parent = r_pid; ap.user = 1'b1;
                        ap.service = r_svc; ap.launchable = r_launch;
                    end
                end
                if (r_kind > KIND_IDLE) begin
                    ap_status = RS_REFUSED;
                end else if (r_x_hit) begin
                    ap_idx = r_x_idx; ap_en = 1'b1; ap_rid = ap.id;
                end else if (r_used >= USED_W'(TASK_SLOTS)) begin
                    ap_status = RS_NONE;
                end else begin
                    ap_idx = r_used[SLOT_W-1:0]; ap_en = 1'b1; ap_rid = ap.id; ap_new = 1'b1;
                end
            end
            MODE_READY: begin
                if (!r_f_hit) ap_status = RS_NOTASK;
                else if (r_f_slot.status == ST_EXITED) ap_status = RS_REFUSED;
                else begin
                    ap.status = ST_READY; ap.deadline = '0; ap.window = '0; ap_en = 1'b1;
                end
            end
            MODE_SLEEP: begin
                ap = r_c_slot; ap_idx = r_c_idx;
                if (!r_c_hit) ap_status = RS_NOTASK;
                else if (r_c_slot.id == '0 || r_c_slot.status == ST_EXITED)
                    ap_status = RS_REFUSED;
                else begin
                    ap.status = ST_BLOCKED; ap.deadline = r_dl; ap.window = r_win; ap_en = 1'b1;
                end
            end
            MODE_WAKE: begin
                if (!r_f_hit) ap_status = RS_NOTASK;
                else if (r_f_slot.status != ST_BLOCKED || r_f_slot.window != r_win)
                    ap_status = RS_REFUSED;
                else begin
                    ap.status = ST_READY; ap.deadline = '0; ap.window = '0; ap_en = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_raddr_q;
        ram_wdata = wb;
        if (r_state == S_MID && r_pass && r_rvalid && per_slot_mode) begin
            ram_we = wb_en;
        end else if (r_state == S_APPLY) begin
            ram_we = ap_en; ram_waddr = ap_idx; ram_wdata = ap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_next_id <= 32'd1;
            r_cur_id  <= '0;
            r_tick    <= '0;
            r_busy    <= '0;
            r_idle    <= '0;
            r_rvalid  <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid  <= r_state == S_DONE;
            r_rvalid <= scan_issue;
            r_raddr_q <= ram_raddr;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode <= t_mode'(i_mode);
                        r_tid <= i_task_id; r_pid <= i_parent_id; r_kind <= i_task_kind;
                        r_svc <= i_service_flag; r_launch <= i_launchable;
                        r_dl <= i_wake_deadline; r_win <= i_window_id;
                        r_pass <= 1'b0; r_cnt <= '0;
                        r_f_hit <= 1'b0; r_c_hit <= 1'b0; r_x_hit <= 1'b0;
                        r_sel_hit <= 1'b0; r_hit_any <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN, S_MID: begin
                    if (scan_issue) r_cnt <= r_cnt + 1'b1;
                    if (r_rvalid && !r_pass) begin
                        if (!r_f_hit && rd.id == r_tid) begin
                            r_f_hit <= 1'b1; r_f_idx <= r_raddr_q; r_f_slot <= rd;
                        end
                        if (!r_c_hit && rd.id == r_cur_id) begin
                            r_c_hit <= 1'b1; r_c_idx <= r_raddr_q; r_c_slot <= rd;
                        end
                        if (!r_x_hit && rd.status == ST_EXITED) begin
                            r_x_hit <= 1'b1; r_x_idx <= r_raddr_q;
                        end
                    end
                    if (r_rvalid && r_pass) begin
                        if (r_mode == MODE_RUN && rd.id == r_tid) r_hit_any <= 1'b1;
                        if (r_mode == MODE_SELECT && !r_sel_hit && eligible && !rd.service) begin
                            r_sel_hit <= 1'b1; r_sel_id <= rd.id;
                        end
                        if (r_mode == MODE_SELECT && !r_hit_any && eligible && rd.service) begin
                            r_hit_any <= 1'b1; r_f_slot <= rd;
                        end
                    end
                    if (!scan_issue && !r_rvalid) begin
                        if (!r_pass) begin
                            r_pass <= 1'b1; r_cnt <= '0;
                            if (r_mode == MODE_TICK) begin
                                r_tick <= r_tick + 1'b1;
                                if (r_c_hit && r_c_slot.status == ST_RUNNING)
                                    r_busy <= r_busy + 1'b1;
                                else
                                    r_idle <= r_idle + 1'b1;
                            end
                            r_state <= (per_slot_mode || r_mode == MODE_SELECT) ? S_MID : S_APPLY;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_APPLY: begin
                    unique case (r_mode)
                        MODE_RUN: begin
                            r_cur_id <= r_tid;
                            r_res_status <= r_hit_any ? RS_OK : RS_NOTASK;
                            o_result_id <= '0;
                        end
                        MODE_EXIT: begin
                            if (r_cur_id == r_tid) r_cur_id <= '0;
                            r_res_status <= r_f_hit ? RS_OK : RS_NOTASK;
                            o_result_id <= '0;
                        end
                        MODE_SELECT: begin
                            if (r_sel_hit) begin
                                r_res_status <= RS_OK; o_result_id <= r_sel_id;
                            end else if (r_hit_any) begin
                                r_res_status <= RS_OK; o_result_id <= r_f_slot.id;
                            end else begin
                                r_res_status <= RS_NONE; o_result_id <= '0;
                            end
                        end
                        MODE_CREATE: begin
                            r_res_status <= ap_status;
                            o_result_id <= ap_rid;
                            if (ap_new) r_used <= r_used + 1'b1;
                            if (ap_en && r_kind != KIND_IDLE) r_next_id <= r_next_id + 1'b1;
                        end
                        default: begin
                            r_res_status <= ap_status;
                            o_result_id <= ap_rid;
                        end
                    endcase
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = r_state != S_IDLE;
    assign o_status     = r_res_status;
    assign o_tick_count = r_tick;
    assign o_busy_ticks = r_busy;
    assign o_idle_ticks = r_idle;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TASK_SLOTS))
        else $error("slot count beyond table");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_mode != MODE_TICK) |=> $stable(r_tick))
        else $error("tick counter moved outside tick");
endmodule

[dv/tb_task_table_round_robin_scheduler_core.sv]
// Self-checking testbench for the round-robin task table scheduler core.
// Drives random and directed scheduler requests, predicts each result, compares.
// Depends on ttrr_pkg and task_table_round_robin_scheduler_core.
`timescale 1ns / 1ps

module tb_task_table_round_robin_scheduler_core
    import ttrr_pkg::*;
();

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] task_id;
        logic [31:0] parent_id;
        logic [1:0]  kind;
        logic        service;
        logic        launchable;
        logic [63:0] deadline;
        logic [31:0] window;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_id;
        logic [63:0] ticks;
        logic [63:0] busy_cnt;
        logic [63:0] idle_cnt;
    } t_resp;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_mode = '0;
    logic [31:0] i_task_id = '0;
    logic [31:0] i_parent_id = '0;
    logic [1:0]  i_task_kind = '0;
    logic        i_service_flag = 1'b0;
    logic        i_launchable = 1'b0;
    logic [63:0] i_wake_deadline = '0;
    logic [31:0] i_window_id = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_result_id;
    logic [63:0] o_tick_count;
    logic [63:0] o_busy_ticks;
    logic [63:0] o_idle_ticks;

    task_table_round_robin_scheduler_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // scheduler shadow state
    t_slot       table_q [TASK_SLOTS];
    int          used_slots;
    logic [31:0] id_counter;
    logic [31:0] cur_id;
    logic [63:0] tick_cnt, busy_cnt, idle_cnt;

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    int    errors = 0;
    bit    quiet_phase = 0;
    int    idle_cycles = 0;
    int    gap_left = 0;
    logic  busy_q;

    function automatic int find_slot(logic [31:0] id);
        for (int i = 0; i < used_slots; i++)
            if (table_q[i].id == id) return i;
        return -1;
    endfunction

    function automatic t_resp schedule(t_req r);
        t_resp o;
        int f, s, st;
        bit hit;
        o = '0;
        case (t_mode'(r.mode))
            MODE_TICK: begin
                tick_cnt++;
                f = find_slot(cur_id);
                if (f >= 0 && table_q[f].status == ST_RUNNING) busy_cnt++;
                else idle_cnt++;
                for (int i = 0; i < used_slots; i++)
                    if (table_q[i].status == ST_BLOCKED && table_q[i].deadline != 0 &&
                        table_q[i].deadline <= tick_cnt) begin
                        table_q[i].status = ST_READY;
                        table_q[i].deadline = '0;
                        table_q[i].window = '0;
                    end
            end
            MODE_CREATE: begin
                if (r.kind > KIND_IDLE) begin
                    o.status = RS_REFUSED;
                end else begin
                    s = -1;
                    for (int i = 0; i < used_slots; i++)
                        if (s < 0 && table_q[i].status == ST_EXITED) s = i;
                    if (s < 0 && used_slots >= TASK_SLOTS) begin
                        o.status = RS_NONE;
                    end else begin
                        if (s < 0) s = used_slots++;
                        table_q[s] = '0;
                        if (r.kind == KIND_IDLE) begin
                            table_q[s].status = ST_RUNNING;
                        end else begin
                            table_q[s].id = id_counter++;
                            table_q[s].status = ST_READY;
                            if (r.kind == KIND_USER) begin
                                table_q[s].parent = r.parent_id;
                                table_q[s].user = 1'b1;
                                table_q[s].service = r.service;
                                table_q[s].launchable = r.launchable;
                            end
                        end
                        o.result_id = table_q[s].id;
                    end
                end
            end
            MODE_RUN: begin
                cur_id = r.task_id;
                hit = 0;
                for (int i = 0; i < used_slots; i++)
                    if (table_q[i].id == r.task_id) begin
                        table_q[i].status = ST_RUNNING;
                        hit = 1;
                    end else if (table_q[i].status == ST_RUNNING) begin
                        table_q[i].status = ST_READY;
                    end
                o.status = hit ? RS_OK : RS_NOTASK;
            end
            MODE_EXIT: begin
                f = find_slot(r.task_id);
                if (f >= 0) table_q[f].status = ST_EXITED;
                for (int i = 0; i < used_slots; i++)
                    if (table_q[i].parent == r.task_id) table_q[i].parent = '0;
                if (cur_id == r.task_id) cur_id = '0;
                o.status = f >= 0 ? RS_OK : RS_NOTASK;
            end
            MODE_READY, MODE_WAKE: begin
                f = find_slot(r.task_id);
                if (f < 0) o.status = RS_NOTASK;
                else if (r.mode == MODE_READY && table_q[f].status == ST_EXITED)
                    o.status = RS_REFUSED;
                else if (r.mode == MODE_WAKE && (table_q[f].status != ST_BLOCKED ||
                         table_q[f].window != r.window))
                    o.status = RS_REFUSED;
                else begin
                    table_q[f].status = ST_READY;
                    table_q[f].deadline = '0;
                    table_q[f].window = '0;
                end
            end
            MODE_SLEEP: begin
                f = find_slot(cur_id);
                if (f < 0) o.status = RS_NOTASK;
                else if (table_q[f].id == 0 || table_q[f].status == ST_EXITED)
                    o.status = RS_REFUSED;
                else begin
                    table_q[f].window = r.window;
                    table_q[f].deadline = r.deadline;
                    table_q[f].status = ST_BLOCKED;
                end
            end
            default: begin
                o.status = RS_NONE;
                if (used_slots > 0) begin
                    f = find_slot(cur_id);
                    st = f >= 0 ? f : 0;
                    for (int p = 0; p < 2 && o.status == RS_NONE; p++) begin
                        s = st;
                        for (int n = 0; n < used_slots; n++) begin
                            s = s + 1;
                            if (s >= used_slots) s = 0;
                            if (table_q[s].user && table_q[s].status == ST_READY &&
                                table_q[s].launchable && !(p == 0 && table_q[s].service)) begin
                                o.status = RS_OK;
                                o.result_id = table_q[s].id;
                                break;
                            end
                        end
                    end
                end
            end
        endcase
        o.ticks = tick_cnt;
        o.busy_cnt = busy_cnt;
        o.idle_cnt = idle_cnt;
        return o;
    endfunction

    function automatic logic [31:0] pick_id();
        int n;
        n = $urandom_range(0, 9);
        if (n < 7 && used_slots > 0) return table_q[$urandom_range(0, used_slots - 1)].id;
        if (n == 7) return '0;
        if (n == 8) return id_counter;
        return $urandom;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int n;
        r.mode = 3'($urandom_range(0, 7));
        n = $urandom_range(0, 99);
        if (n < 20) r.mode = MODE_TICK;
        else if (n < 35) r.mode = MODE_CREATE;
        r.task_id = pick_id();
        r.parent_id = $urandom_range(0, 1) ? pick_id() : $urandom;
        r.kind = $urandom_range(0, 19) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) r.kind = KIND_USER;
        r.service = $urandom_range(0, 3) == 0;
        r.launchable = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 4))
            0: r.deadline = '0;
            1: r.deadline = {$urandom, $urandom};
            2: r.deadline = '1;
            default: r.deadline = tick_cnt + 64'($urandom_range(1, 12));
        endcase
        r.window = $urandom_range(0, 2) == 0 ? $urandom : 32'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic t_req mk(logic [2:0] m, logic [31:0] tid, logic [1:0] k,
                                logic [63:0] dl, logic [31:0] w);
        t_req r;
        r = '0;
        r.mode = m;
        r.task_id = tid;
        r.parent_id = 32'hFFFF_FFFF;
        r.kind = k;
        r.service = 1'b0;
        r.launchable = 1'b1;
        r.deadline = dl;
        r.window = w;
        return r;
    endfunction

    // driver: requests go through the shadow model as they are accepted
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy_q) begin
                start <= 1'b0;
            end else if (!start && pending_reqs.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                    gap_left <= $urandom_range(1, 14);
                end else begin
                    t_req r;
                    r = pending_reqs.pop_front();
                    start <= 1'b1;
                    i_mode <= r.mode;
                    i_task_id <= r.task_id;
                    i_parent_id <= r.parent_id;
                    i_task_kind <= r.kind;
                    i_service_flag <= r.service;
                    i_launchable <= r.launchable;
                    i_wake_deadline <= r.deadline;
                    i_window_id <= r.window;
                end
            end
        end
    end

    always @(posedge i_clk) busy_q <= busy;

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (start && !busy) begin
                expected_resps.push_back(schedule({i_mode, i_task_id, i_parent_id,
                    i_task_kind, i_service_flag, i_launchable, i_wake_deadline,
                    i_window_id}));
            end
            if (o_valid) begin
                if (expected_resps.size() == 0) begin
                    $display("%0t: unexpected result status=%0d", $time, o_status);
                    errors <= errors + 1;
                end else begin
                    t_resp e;
                    e = expected_resps.pop_front();
                    if (e != {o_status, o_result_id, o_tick_count, o_busy_ticks,
                              o_idle_ticks}) begin
                        $display("%0t: mismatch expected st=%0d id=%h tk=%0d bz=%0d id=%0d",
                                 $time, e.status, e.result_id, e.ticks, e.busy_cnt,
                                 e.idle_cnt);
                        $display("%0t:          actual st=%0d id=%h tk=%0d bz=%0d id=%0d",
                                 $time, o_status, o_result_id, o_tick_count, o_busy_ticks,
                                 o_idle_ticks);
                        errors <= errors + 1;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_req r;
        used_slots = 0;
        id_counter = 32'd1;
        cur_id = '0;
        tick_cnt = '0;
        busy_cnt = '0;
        idle_cnt = '0;
        foreach (table_q[i]) table_q[i] = '0;
        // directed: empty table, creates of each kind, lifecycle, wraps at the end
        pending_reqs.push_back(mk(MODE_SELECT, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, 5, 0));
        pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_CREATE, 0, KIND_IDLE, 0, 0));
        pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, 5, 0));
        pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_CREATE, 0, KIND_KERNEL, 0, 0));
        pending_reqs.push_back(mk(MODE_CREATE, 0, KIND_USER, 0, 0));
        pending_reqs.push_back(mk(MODE_CREATE, 0, 2'd3, 0, 0));
        r = mk(MODE_CREATE, 0, KIND_USER, 0, 0);
        r.service = 1'b1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(mk(MODE_SELECT, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_RUN, 2, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_SELECT, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, 2, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(MODE_WAKE, 2, 0, 0, 7));
        pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_WAKE, 2, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(MODE_RUN, 2, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_WAKE, 2, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_READY, 32'hFFFF_FFFF, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_EXIT, 2, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_READY, 2, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_EXIT, 99, 0, 0, 0));
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        // random: shadow state is used as a hint only, so generate in small batches
        for (int n = 0; n < 1650; n++) begin
            wait (pending_reqs.size() < 2);
            if (n == 1400) quiet_phase = 1;
            pending_reqs.push_back(random_req());
        end
        wait (pending_reqs.size() == 0 && !start);
        wait (expected_resps.size() == 0);
        repeat (2 * TASK_SLOTS + 20) @(posedge i_clk);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[task_table_round_robin_scheduler_core.f]
src/ttrr_pkg.sv
src/ttrr_slot_ram.sv
src/task_table_round_robin_scheduler_core.sv
dv/tb_task_table_round_robin_scheduler_core.sv
